// ----- sv/dq_pkg.sv -----
// Shared types and codes for the bounded double-ended queue.
package dq_pkg;

   localparam int DATA_W  = 32;
   localparam int CAP_W   = 11;
   localparam int OP_W    = 3;

   localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_FRONT  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_BACK   = 3'd2;
   localparam logic [OP_W-1:0] OP_REM_FRONT  = 3'd3;
   localparam logic [OP_W-1:0] OP_REM_BACK   = 3'd4;

   localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] rear_value;
      logic                     empty_res;
      logic                     full_res;
      logic [CAP_W-1:0]         entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_RESP
   } state_type;

endpackage

// ----- sv/dq_ring_ram.sv -----
// Ring storage: one write port and two registered read ports.
module dq_ring_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [AW-1:0]                    wr_addr,
   input  logic signed [dq_pkg::DATA_W-1:0] wr_data,
   input  logic                             rd_en,
   input  logic [AW-1:0]                    rd_front_addr,
   input  logic [AW-1:0]                    rd_rear_addr,
   output logic signed [dq_pkg::DATA_W-1:0] rd_front_data,
   output logic signed [dq_pkg::DATA_W-1:0] rd_rear_data
);

   logic signed [dq_pkg::DATA_W-1:0] mem [DEPTH];
   logic signed [dq_pkg::DATA_W-1:0] front_ff;
   logic signed [dq_pkg::DATA_W-1:0] rear_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         front_ff <= mem[rd_front_addr];
         rear_ff  <= mem[rd_rear_addr];
      end
   end

   assign rd_front_data = front_ff;
   assign rd_rear_data  = rear_ff;

endmodule

// ----- sv/dq_ctrl.sv -----
// Pointer, count and capacity control with the response register.
module dq_ctrl #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  dq_pkg::req_type                  req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output dq_pkg::rsp_type                  rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dq_pkg::CAP_W-1:0]         csr_data,
   output logic                             wr_en,
   output logic [AW-1:0]                    wr_addr,
   output logic signed [dq_pkg::DATA_W-1:0] wr_data,
   output logic                             rd_en,
   output logic [AW-1:0]                    rd_front_addr,
   output logic [AW-1:0]                    rd_rear_addr,
   input  logic signed [dq_pkg::DATA_W-1:0] rd_front_data,
   input  logic signed [dq_pkg::DATA_W-1:0] rd_rear_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int KW = (CW > dq_pkg::CAP_W) ? CW : dq_pkg::CAP_W;
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   dq_pkg::state_type       state_ff, state_in;
   logic [AW-1:0]           head_ff, head_in;
   logic [AW-1:0]           tail_ff, tail_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [dq_pkg::CAP_W-1:0] cap_ff;
   logic                    ok_ff, ok_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   dq_pkg::rsp_type         rsp_ff, rsp_in;

   logic                    req_fire;
   logic [KW-1:0]           cap_ext;
   logic [KW-1:0]           eff_cap;
   logic                    is_full;
   logic                    is_empty;

   function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
      return (i == LAST_IDX) ? '0 : i + AW'(1);
   endfunction

   function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
      return (i == '0) ? LAST_IDX : i - AW'(1);
   endfunction

   assign req_stall = (state_ff != dq_pkg::ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // A capacity above the ring depth saturates at the depth.
   assign cap_ext  = KW'(cap_ff);
   assign eff_cap  = (cap_ext > KW'(DEPTH)) ? KW'(DEPTH) : cap_ext;
   assign is_full  = (KW'(count_ff) >= eff_cap);
   assign is_empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dq_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= dq_pkg::CAP_W'(1024);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      ok_ff  <= ok_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      ok_in         = ok_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      wr_en         = 1'b0;
      wr_addr       = tail_ff;
      wr_data       = req_data.value;
      rd_en         = 1'b0;
      rd_front_addr = head_ff;
      rd_rear_addr  = idx_prev(tail_ff);

      case (state_ff)
         dq_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = dq_pkg::ST_READ;
               ok_in    = 1'b0;
               case (req_data.op)
                  dq_pkg::OP_NONE: begin
                     ok_in = 1'b1;
                  end
                  dq_pkg::OP_INS_FRONT: begin
                     if (!is_full) begin
                        head_in  = idx_prev(head_ff);
                        wr_en    = 1'b1;
                        wr_addr  = idx_prev(head_ff);
                        count_in = count_ff + CW'(1);
                        ok_in    = 1'b1;
                     end
                  end
                  dq_pkg::OP_INS_BACK: begin
                     if (!is_full) begin
                        tail_in  = idx_next(tail_ff);
                        wr_en    = 1'b1;
                        wr_addr  = tail_ff;
                        count_in = count_ff + CW'(1);
                        ok_in    = 1'b1;
                     end
                  end
                  dq_pkg::OP_REM_FRONT: begin
                     if (!is_empty) begin
                        head_in  = idx_next(head_ff);
                        count_in = count_ff - CW'(1);
                        ok_in    = 1'b1;
                     end
                  end
                  dq_pkg::OP_REM_BACK: begin
                     if (!is_empty) begin
                        tail_in  = idx_prev(tail_ff);
                        count_in = count_ff - CW'(1);
                        ok_in    = 1'b1;
                     end
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         dq_pkg::ST_READ: begin
            // Pointers already hold their new values, so the ends are read here.
            rd_en    = 1'b1;
            state_in = dq_pkg::ST_RESP;
         end
         dq_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.ok          = ok_ff;
               rsp_in.front_value = is_empty ? dq_pkg::EMPTY_VALUE : rd_front_data;
               rsp_in.rear_value  = is_empty ? dq_pkg::EMPTY_VALUE : rd_rear_data;
               rsp_in.empty_res   = is_empty;
               rsp_in.full_res    = is_full;
               rsp_in.entry_count = dq_pkg::CAP_W'(count_ff);
               rsp_valid_in       = 1'b1;
               state_in           = dq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- sv/bounded_double_ended_queue.sv -----
// Top level of the bounded double-ended queue.
//
// Request channel (req_valid, req_stall, req_data) carries one operation per
// beat: query, insert at front or back, remove from front or back. The
// response channel (rsp_valid, rsp_stall, rsp_data) returns one beat per
// request with the status, both end values, the flags and the entry count.
// The capacity register is written through csr_valid, csr_ready, csr_data;
// csr_ready is always high and writes belong to idle periods.
// Each request passes in order through the pointer update and ring write,
// the read of both ends from the ring memory, and the load of the response
// register. The ring memory's read ports are registered and the ends are
// read only once the pointers hold their new values, so a new request is
// taken only after the response register has been loaded for the last one.
// While the receiver stalls, the held response stays unchanged and a
// finished result waits in the control block before the next request.
// Reset clears the pointers and the count and sets the capacity to 1024;
// the ring memory is not cleared, as only live entries are ever reported.
module bounded_double_ended_queue #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  dq_pkg::req_type          req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output dq_pkg::rsp_type          rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [dq_pkg::CAP_W-1:0] csr_data
);

   localparam int AW = $clog2(DEPTH);

   logic                             wr_en;
   logic [AW-1:0]                    wr_addr;
   logic signed [dq_pkg::DATA_W-1:0] wr_data;
   logic                             rd_en;
   logic [AW-1:0]                    rd_front_addr;
   logic [AW-1:0]                    rd_rear_addr;
   logic signed [dq_pkg::DATA_W-1:0] rd_front_data;
   logic signed [dq_pkg::DATA_W-1:0] rd_rear_data;

   dq_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_front_addr (rd_front_addr),
      .rd_rear_addr  (rd_rear_addr),
      .rd_front_data (rd_front_data),
      .rd_rear_data  (rd_rear_data)
   );

   dq_ring_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock         (clock),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_front_addr (rd_front_addr),
      .rd_rear_addr  (rd_rear_addr),
      .rd_front_data (rd_front_data),
      .rd_rear_data  (rd_rear_data)
   );

endmodule

// ----- sv/dq_checker.sv -----
// Port-level checks for the bounded double-ended queue, bound to the top level.
module dq_checker #(
   parameter int DEPTH = 1024
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input dq_pkg::req_type          req_data,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input dq_pkg::rsp_type          rsp_data,
   input logic                     csr_valid,
   input logic                     csr_ready,
   input logic [dq_pkg::CAP_W-1:0] csr_data
);

   // A held response beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // One request is in flight at a time, so a beat is never taken back to back.
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted in consecutive cycles");

   // An empty queue reports no entries and the empty marker at both ends.
   a_empty_view: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_res |->
         rsp_data.entry_count == '0 &&
         rsp_data.front_value == dq_pkg::EMPTY_VALUE &&
         rsp_data.rear_value == dq_pkg::EMPTY_VALUE)
      else $error("empty response with entries or live values");

   // The count never exceeds the ring depth where the count field can show it.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DEPTH > 2047) ||
         (rsp_data.entry_count <= dq_pkg::CAP_W'(DEPTH)))
      else $error("entry count beyond ring depth");

   // A nonzero count contradicts the empty flag.
   a_count_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_count != '0 |-> !rsp_data.empty_res)
      else $error("empty flag with a nonzero count");

   logic unused_inputs;
   assign unused_inputs = ^{req_data, csr_valid, csr_ready, csr_data};

endmodule

bind bounded_double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);

// ----- verif/tb_bounded_double_ended_queue.sv -----
// Self-checking testbench for the bounded double-ended queue.
`timescale 1ns / 100ps

module tb_bounded_double_ended_queue;

   localparam int DQ_DEPTH    = 1024;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE      = 8;
   localparam int SIDE_REQ    = 0;
   localparam int SIDE_RSP    = 1;

   // Codes outside the defined set, which the block must answer as a failed query.
   localparam logic [dq_pkg::OP_W-1:0] OP_BAD_LOW  = dq_pkg::OP_REM_BACK + 1'b1;
   localparam logic [dq_pkg::OP_W-1:0] OP_BAD_HIGH = '1;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   dq_pkg::req_type          req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   dq_pkg::rsp_type          rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [dq_pkg::CAP_W-1:0] csr_data = '0;

   bounded_double_ended_queue #(
      .DEPTH(DQ_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of the deque.
   logic signed [dq_pkg::DATA_W-1:0] shadow_ring [DQ_DEPTH];
   int shadow_head;
   int shadow_tail;
   int shadow_count;
   int shadow_capacity;

   dq_pkg::req_type pending_ops[$];
   dq_pkg::rsp_type predicted_status[$];

   int req_beats_sent  = 0;
   int req_beats_taken = 0;
   int rsp_beats_taken = 0;
   int rsp_beats_seen  = 0;
   int csr_writes      = 0;
   int req_gap         = 0;
   int rsp_hold        = 0;
   int quiet_cycles    = 0;
   int mismatch_count  = 0;
   int calm_left [2]   = '{0, 0};

   function automatic dq_pkg::rsp_type apply_deque_op(dq_pkg::req_type item);
      dq_pkg::rsp_type outcome;
      int              limit;
      limit = (shadow_capacity > DQ_DEPTH) ? DQ_DEPTH : shadow_capacity;
      outcome = '0;
      case (item.op)
         dq_pkg::OP_NONE: begin
            outcome.ok = 1'b1;
         end
         dq_pkg::OP_INS_FRONT: begin
            if (shadow_count < limit) begin
               shadow_head = (shadow_head + DQ_DEPTH - 1) % DQ_DEPTH;
               shadow_ring[shadow_head] = item.value;
               shadow_count++;
               outcome.ok = 1'b1;
            end
         end
         dq_pkg::OP_INS_BACK: begin
            if (shadow_count < limit) begin
               shadow_ring[shadow_tail] = item.value;
               shadow_tail = (shadow_tail + 1) % DQ_DEPTH;
               shadow_count++;
               outcome.ok = 1'b1;
            end
         end
         dq_pkg::OP_REM_FRONT: begin
            if (shadow_count != 0) begin
               shadow_head = (shadow_head + 1) % DQ_DEPTH;
               shadow_count--;
               outcome.ok = 1'b1;
            end
         end
         dq_pkg::OP_REM_BACK: begin
            if (shadow_count != 0) begin
               shadow_tail = (shadow_tail + DQ_DEPTH - 1) % DQ_DEPTH;
               shadow_count--;
               outcome.ok = 1'b1;
            end
         end
         default: begin
            outcome.ok = 1'b0;
         end
      endcase
      outcome.empty_res   = (shadow_count == 0);
      outcome.full_res    = (shadow_count >= limit);
      outcome.entry_count = shadow_count[dq_pkg::CAP_W-1:0];
      outcome.front_value = outcome.empty_res ? dq_pkg::EMPTY_VALUE :
                            shadow_ring[shadow_head];
      outcome.rear_value  = outcome.empty_res ? dq_pkg::EMPTY_VALUE :
                            shadow_ring[(shadow_tail + DQ_DEPTH - 1) % DQ_DEPTH];
      return outcome;
   endfunction

   // Wait before the next beat; now and then a run of back-to-back beats.
   function automatic int draw_wait(int side);
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm_left[side] = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 7);
   endfunction

   function automatic dq_pkg::req_type random_op(int ins_pct, int rem_pct);
      dq_pkg::req_type item;
      int              roll;
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) begin
         item.op = $urandom_range(0, 1) ? dq_pkg::OP_INS_FRONT : dq_pkg::OP_INS_BACK;
      end else if (roll < ins_pct + rem_pct) begin
         item.op = $urandom_range(0, 1) ? dq_pkg::OP_REM_FRONT : dq_pkg::OP_REM_BACK;
      end else if ($urandom_range(0, 2) != 0) begin
         item.op = dq_pkg::OP_NONE;
      end else begin
         item.op = dq_pkg::OP_W'($urandom_range(OP_BAD_LOW, OP_BAD_HIGH));
      end
      case ($urandom_range(0, 9))
         0:       item.value = 32'sh8000_0000;
         1:       item.value = 32'sh7FFF_FFFF;
         2:       item.value = dq_pkg::EMPTY_VALUE;
         3:       item.value = '0;
         default: item.value = $urandom;
      endcase
      return item;
   endfunction

   task automatic add_op(input logic [dq_pkg::OP_W-1:0] op,
                         input logic signed [dq_pkg::DATA_W-1:0] value);
      dq_pkg::req_type item;
      item.op    = op;
      item.value = value;
      pending_ops.push_back(item);
   endtask

   task automatic add_random_ops(input int count, input int ins_pct, input int rem_pct);
      repeat (count) pending_ops.push_back(random_op(ins_pct, rem_pct));
   endtask

   task automatic wait_until_drained();
      while (pending_ops.size() != 0 || req_beats_sent != req_beats_taken ||
             predicted_status.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [dq_pkg::CAP_W-1:0] capacity);
      int writes_before;
      wait_until_drained();
      writes_before = csr_writes;
      csr_data  <= capacity;
      csr_valid <= 1'b1;
      while (csr_writes == writes_before) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string field, input logic [dq_pkg::DATA_W-1:0] want,
                              input logic [dq_pkg::DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endtask

   // Request driver: the payload holds until the beat is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_beats_sent != req_beats_taken)) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (pending_ops.size() != 0) begin
            req_data  <= pending_ops.pop_front();
            req_valid <= 1'b1;
            req_beats_sent++;
            req_gap = draw_wait(SIDE_REQ);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure: a fresh stall length after every beat taken.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_beats_seen != rsp_beats_taken) begin
            rsp_beats_seen = rsp_beats_taken;
            rsp_hold = draw_wait(SIDE_RSP);
         end
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: prediction on each accepted request, checking on each response.
   always @(posedge clock) begin
      if (reset) begin
         shadow_head     = 0;
         shadow_tail     = 0;
         shadow_count    = 0;
         shadow_capacity = 1024;
      end else begin
         if (csr_valid && csr_ready) begin
            shadow_capacity = int'(csr_data);
            csr_writes++;
         end
         if (req_valid && !req_stall) begin
            predicted_status.push_back(apply_deque_op(req_data));
            req_beats_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_beats_taken++;
            if (predicted_status.size() == 0) begin
               $error("response beat with no prediction waiting");
               mismatch_count++;
            end else begin
               dq_pkg::rsp_type want;
               want = predicted_status.pop_front();
               check_field("ok", dq_pkg::DATA_W'(want.ok),
                           dq_pkg::DATA_W'(rsp_data.ok));
               check_field("front_value", want.front_value, rsp_data.front_value);
               check_field("rear_value", want.rear_value, rsp_data.rear_value);
               check_field("empty_res", dq_pkg::DATA_W'(want.empty_res),
                           dq_pkg::DATA_W'(rsp_data.empty_res));
               check_field("full_res", dq_pkg::DATA_W'(want.full_res),
                           dq_pkg::DATA_W'(rsp_data.full_res));
               check_field("entry_count", dq_pkg::DATA_W'(want.entry_count),
                           dq_pkg::DATA_W'(rsp_data.entry_count));
            end
         end
         if ((csr_valid && csr_ready) || (req_valid && !req_stall) ||
             (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(negedge clock);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset capacity: failures on an empty deque, both ends, odd codes.
      add_op(dq_pkg::OP_NONE, '0);
      add_op(dq_pkg::OP_REM_FRONT, '0);
      add_op(dq_pkg::OP_REM_BACK, '0);
      add_op(OP_BAD_LOW, 32'sd5);
      add_op(dq_pkg::OP_INS_BACK, 32'sh7FFF_FFFF);
      add_op(dq_pkg::OP_INS_FRONT, 32'sh8000_0000);
      add_op(dq_pkg::OP_INS_BACK, dq_pkg::EMPTY_VALUE);
      add_op(OP_BAD_HIGH, 32'sd123);
      add_op(dq_pkg::OP_INS_FRONT, '0);
      add_op(dq_pkg::OP_NONE, 32'sd77);
      add_op(dq_pkg::OP_REM_BACK, '0);
      add_op(dq_pkg::OP_REM_FRONT, '0);
      add_op(dq_pkg::OP_REM_BACK, '0);
      add_op(dq_pkg::OP_REM_FRONT, '0);
      add_op(dq_pkg::OP_REM_FRONT, '0);
      add_op(dq_pkg::OP_INS_FRONT, 32'sh5A5A_5A5A);

      // Zero capacity with one entry left over; full stays set once empty.
      write_capacity(11'd0);
      add_op(dq_pkg::OP_NONE, '0);
      add_op(dq_pkg::OP_INS_BACK, 32'sd9);
      add_op(dq_pkg::OP_REM_BACK, '0);
      add_op(dq_pkg::OP_INS_FRONT, 32'sd10);
      add_op(dq_pkg::OP_REM_FRONT, '0);

      write_capacity(11'd1);
      add_random_ops(40, 45, 40);

      write_capacity(11'd3);
      add_random_ops(40, 45, 40);

      write_capacity(11'd2);
      add_random_ops(40, 40, 40);

      // Above the ring depth: fill the ring completely so the limit saturates.
      write_capacity(11'h7FF);
      add_random_ops(1030, 100, 0);

      // Lowered well below the count; mostly removes, so full holds throughout.
      write_capacity(11'd8);
      add_random_ops(40, 5, 85);

      write_capacity(11'd1024);
      add_random_ops(30, 50, 35);

      wait_until_drained();
      if (mismatch_count == 0 && predicted_status.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
sv/dq_pkg.sv
sv/dq_ring_ram.sv
sv/dq_ctrl.sv
sv/bounded_double_ended_queue.sv
sv/dq_checker.sv
verif/tb_bounded_double_ended_queue.sv
